FILE: sv/mf3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared widths, reset values, register indexes and types of the 3x3 median
// filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int PIX_W         = 8;
  localparam int CFG_WIDTH_W   = 12;
  localparam int CFG_HEIGHT_W  = 13;
  localparam int CFG_DATA_W    = 13;
  localparam int CFG_IDX_W     = 2;
  localparam int CCOL_W        = 11;
  localparam int ROW_W         = 12;
  localparam int DEF_MAX_WIDTH = 2048;

  localparam logic [CFG_WIDTH_W-1:0]  DEF_IMAGE_WIDTH  = 12'd640;
  localparam logic [CFG_HEIGHT_W-1:0] DEF_IMAGE_HEIGHT = 13'd480;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_LIMIT     = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [8:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic              emit;
    logic              last;
    logic [CCOL_W-1:0] ccol;
    logic [ROW_W-1:0]  crow;
  } pos_t;

endpackage
`default_nettype wire

FILE: sv/mf3_line_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_line_store
// Single-port-write, single-port-read line memory with registered read data
// and write-first bypass on a same-address collision.
// ----------------------------------------------------------------------------
module mf3_line_store #(
  parameter int DEPTH = 2048,
  parameter int DW    = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DW-1:0]            wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/mf3_raster.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_raster
// Column and row counters of the incoming pixel, frame size clamping and the
// interior-pixel decision with centre coordinates.
// ----------------------------------------------------------------------------
module mf3_raster #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [mf3_pkg::CFG_WIDTH_W-1:0]     image_width,
  input  wire logic [mf3_pkg::CFG_HEIGHT_W-1:0]    image_height,
  input  wire logic                                advance,
  output logic      [$clog2(MAX_WIDTH)-1:0]        col,
  output mf3_pkg::pos_t                            pos
);

  import mf3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int XW = ((CW > CFG_WIDTH_W) ? CW : CFG_WIDTH_W) + 1;
  localparam logic [XW-1:0] MAX_W_X = XW'(MAX_WIDTH);

  logic [CW-1:0]           col_r, col_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;
  logic [XW-1:0]           w_eff, c_x, c_1;
  logic [CFG_HEIGHT_W-1:0] h_eff, r_x, r_1;

  always_comb begin
    w_eff = XW'(image_width);
    if (w_eff > MAX_W_X) begin
      w_eff = MAX_W_X;
    end
    if (w_eff == '0) begin
      w_eff = XW'(1);
    end
    h_eff = image_height;
    if (h_eff > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_LIMIT;
    end
    if (h_eff == '0) begin
      h_eff = CFG_HEIGHT_W'(1);
    end
  end

  assign c_x = XW'(col_r);
  assign c_1 = c_x + XW'(1);
  assign r_x = CFG_HEIGHT_W'(row_r);
  assign r_1 = r_x + CFG_HEIGHT_W'(1);

  always_comb begin
    pos.emit = (w_eff >= XW'(3)) && (h_eff >= CFG_HEIGHT_W'(3)) &&
               (c_x >= XW'(2)) && (r_x >= CFG_HEIGHT_W'(2)) &&
               (c_x < w_eff) && (r_x < h_eff);
    pos.last = (c_1 == w_eff) && (r_1 == h_eff);
    pos.ccol = CCOL_W'(c_x - XW'(1));
    pos.crow = row_r - ROW_W'(1);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (c_1 >= w_eff) begin
        col_nxt = '0;
        row_nxt = (r_1 >= h_eff) ? '0 : r_1[ROW_W-1:0];
      end else begin
        col_nxt = c_1[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col = col_r;

endmodule
`default_nettype wire

FILE: sv/mf3_median9.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mf3_median9
// Nineteen-exchange selection network giving the median of nine pixels.
// ----------------------------------------------------------------------------
module mf3_median9 (
  input  wire mf3_pkg::win_t win,
  output mf3_pkg::pix_t      median
);

  import mf3_pkg::*;

  function automatic win_t xchg(win_t p, logic [3:0] a, logic [3:0] b);
    win_t q;
    q = p;
    if (p[a] > p[b]) begin
      q[a] = p[b];
      q[b] = p[a];
    end
    return q;
  endfunction

  win_t p;

  always_comb begin
    p = win;
    p = xchg(p, 4'd1, 4'd2);
    p = xchg(p, 4'd4, 4'd5);
    p = xchg(p, 4'd7, 4'd8);
    p = xchg(p, 4'd0, 4'd1);
    p = xchg(p, 4'd3, 4'd4);
    p = xchg(p, 4'd6, 4'd7);
    p = xchg(p, 4'd1, 4'd2);
    p = xchg(p, 4'd4, 4'd5);
    p = xchg(p, 4'd7, 4'd8);
    p = xchg(p, 4'd0, 4'd3);
    p = xchg(p, 4'd5, 4'd8);
    p = xchg(p, 4'd4, 4'd7);
    p = xchg(p, 4'd3, 4'd6);
    p = xchg(p, 4'd1, 4'd4);
    p = xchg(p, 4'd2, 4'd5);
    p = xchg(p, 4'd4, 4'd7);
    p = xchg(p, 4'd4, 4'd2);
    p = xchg(p, 4'd6, 4'd4);
    p = xchg(p, 4'd4, 4'd2);
    median = p[4];
  end

endmodule
`default_nettype wire

FILE: sv/median_filter_3x3.sv
`default_nettype none
// ----------------------------------------------------------------------------
// median_filter_3x3
// Streaming 3x3 median filter for 8-bit grey frames in raster order.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock unless the output is stalled. The pixel
// that completes a window is registered in the input stage beside the
// registered line-store read, and the median network feeds the output
// register from there. Only interior pixels produce a word, tagged with the
// centre column and row; tlast marks the last one of a frame. Both line
// stores share one memory of MAX_WIDTH words that needs no clearing after
// reset. Write image_width and image_height only while the stream is idle;
// frame sizes clamp to MAX_WIDTH and 4096.
// ----------------------------------------------------------------------------
module median_filter_3x3 #(
  parameter int MAX_WIDTH = mf3_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [7:0]                        in_tdata,   // [7:0] pixel_value
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [7:0] median_value, [18:8] center_col, [30:19] center_row, [31] zero
  output logic      [31:0]                       out_tdata,
  output logic                                   out_tlast,  // frame_last
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mf3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mf3_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import mf3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic [CFG_WIDTH_W-1:0]  width_r;
  logic [CFG_HEIGHT_W-1:0] height_r;

  logic          in_acc, s1_go, out_free;
  logic [CW-1:0] rd_col;
  pos_t          pos;

  logic          s1_valid_r;
  pix_t          s1_pix_r;
  logic [CW-1:0] s1_col_r;
  pos_t          s1_pos_r;

  logic [2*PIX_W-1:0] rd_data;
  pix_t               top, mid;
  pix_t               win_r [6];
  win_t               win;
  pix_t               median;

  logic              out_valid_r;
  pix_t              out_med_r;
  logic [CCOL_W-1:0] out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic              out_last_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DEF_IMAGE_WIDTH;
      height_r <= DEF_IMAGE_HEIGHT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && (!s1_pos_r.emit || out_free);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;

  mf3_raster #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_raster (
    .clk          (clk),
    .rst_n        (rst_n),
    .image_width  (width_r),
    .image_height (height_r),
    .advance      (in_acc),
    .col          (rd_col),
    .pos          (pos)
  );

  mf3_line_store #(
    .DEPTH (MAX_WIDTH),
    .DW    (2 * PIX_W)
  ) u_lines (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_col_r),
    .wdata ({mid, s1_pix_r}),
    .re    (in_acc),
    .raddr (rd_col),
    .rdata (rd_data)
  );

  assign top = rd_data[2*PIX_W-1:PIX_W];
  assign mid = rd_data[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r <= in_tdata;
      s1_col_r <= rd_col;
      s1_pos_r <= pos;
    end
  end

  // advance the window by one column as the word leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_go) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= s1_pix_r;
    end
  end

  assign win = {s1_pix_r, win_r[5], win_r[2],
                mid,      win_r[4], win_r[1],
                top,      win_r[3], win_r[0]};

  mf3_median9 u_median (
    .win    (win),
    .median (median)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r && s1_pos_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_med_r  <= median;
      out_col_r  <= s1_pos_r.ccol;
      out_row_r  <= s1_pos_r.crow;
      out_last_r <= s1_pos_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_row_r, out_col_r, out_med_r};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

FILE: verif/tb_median_filter_3x3.sv
// ----------------------------------------------------------------------------
// tb_median_filter_3x3
// Self-checking testbench for the streaming 3x3 median filter.
// ----------------------------------------------------------------------------
// Pixel words are pushed through the input stream while a line-buffer model
// of the filter, kept in step with every accepted pixel, queues the filtered
// word each interior pixel should produce. Every word on the output stream is
// checked field by field against the oldest queued word. Test tasks cover the
// reset frame size, the smallest frame, sizes below three, saturated width
// and height, resizing part way through a frame, a long output stall and a
// random stream with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_median_filter_3x3;
  import mf3_pkg::*;

  localparam int     HALF_PERIOD   = 10;
  localparam int     RESET_CYCLES  = 7;
  localparam int     SETTLE_CYCLES = 6;
  localparam int     DRAIN_LIMIT   = 20000;
  localparam int     HOLD_CYCLES   = 300;
  localparam longint RUN_LIMIT     = 64'd40_000_000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum int {PIX_UNIFORM, PIX_EXTREME, PIX_CLUSTER, PIX_SPECKLE} pix_mode_t;

  typedef struct packed {
    pix_t              med;
    logic [CCOL_W-1:0] col;
    logic [ROW_W-1:0]  row;
    logic              last;
  } median_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [31:0]           out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  median_filter_3x3 DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // line-buffer model of the filter
  logic [CFG_WIDTH_W-1:0]  img_w;
  logic [CFG_HEIGHT_W-1:0] img_h;
  pix_t                    line_up1 [DEF_MAX_WIDTH];
  pix_t                    line_up2 [DEF_MAX_WIDTH];
  bit                      line_up1_ok [DEF_MAX_WIDTH];
  bit                      line_up2_ok [DEF_MAX_WIDTH];
  pix_t                    win_col [6];
  int unsigned             col_pos;
  int unsigned             row_pos;

  median_word_t medians_due [$];

  int unsigned mismatches        = 0;
  int unsigned pixels_sent       = 0;
  int unsigned medians_predicted = 0;
  int unsigned words_checked     = 0;
  int unsigned sizes_written     = 0;

  bit src_gaps_on   = 1'b1;
  bit sink_gaps_on  = 1'b1;
  bit sink_hold_req = 1'b0;

  function automatic int unsigned eff_width(input logic [CFG_WIDTH_W-1:0] w);
    int unsigned v;
    v = w;
    if (v > DEF_MAX_WIDTH) v = DEF_MAX_WIDTH;
    if (v == 0) v = 1;
    return v;
  endfunction

  function automatic int unsigned eff_height(input logic [CFG_HEIGHT_W-1:0] h);
    int unsigned v;
    v = h;
    if (v > HEIGHT_LIMIT) v = HEIGHT_LIMIT;
    if (v == 0) v = 1;
    return v;
  endfunction

  function automatic pix_t median_of9(input win_t nb);
    int lt;
    int eq;
    for (int i = 0; i < 9; i++) begin
      lt = 0;
      eq = 0;
      for (int j = 0; j < 9; j++) begin
        if (nb[j] < nb[i]) lt++;
        else if (nb[j] == nb[i]) eq++;
      end
      if (lt <= 4 && lt + eq > 4) return nb[i];
    end
    return nb[4];
  endfunction

  // true when every line-store column the new width reads holds written data
  function automatic bit width_fits(input logic [CFG_WIDTH_W-1:0] w);
    int unsigned e;
    e = eff_width(w);
    for (int unsigned i = 0; i < e; i++)
      if (!line_up1_ok[i] || !line_up2_ok[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic reset_window_model();
    img_w   = DEF_IMAGE_WIDTH;
    img_h   = DEF_IMAGE_HEIGHT;
    col_pos = 0;
    row_pos = 0;
    for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
      line_up1[i]    = '0;
      line_up2[i]    = '0;
      line_up1_ok[i] = 1'b0;
      line_up2_ok[i] = 1'b0;
    end
    for (int i = 0; i < 6; i++) win_col[i] = '0;
  endtask

  task automatic advance_window(input pix_t pix);
    int unsigned  w;
    int unsigned  h;
    int unsigned  c;
    int unsigned  r;
    int unsigned  idx;
    pix_t         top;
    pix_t         mid;
    win_t         nb;
    median_word_t mw;
    w   = eff_width(img_w);
    h   = eff_height(img_h);
    c   = col_pos;
    r   = row_pos;
    idx = c % DEF_MAX_WIDTH;
    top = line_up2[idx];
    mid = line_up1[idx];
    if (w >= 3 && h >= 3 && c >= 2 && r >= 2 && c < w && r < h) begin
      nb[0] = win_col[0]; nb[1] = win_col[3]; nb[2] = top;
      nb[3] = win_col[1]; nb[4] = win_col[4]; nb[5] = mid;
      nb[6] = win_col[2]; nb[7] = win_col[5]; nb[8] = pix;
      mw.med  = median_of9(nb);
      mw.col  = CCOL_W'(c - 1);
      mw.row  = ROW_W'(r - 1);
      mw.last = (c + 1 == w) && (r + 1 == h);
      medians_due.push_back(mw);
      medians_predicted++;
    end
    win_col[0] = win_col[3];
    win_col[1] = win_col[4];
    win_col[2] = win_col[5];
    win_col[3] = top;
    win_col[4] = mid;
    win_col[5] = pix;
    line_up2[idx]    = mid;
    line_up2_ok[idx] = line_up1_ok[idx];
    line_up1[idx]    = pix;
    line_up1_ok[idx] = 1'b1;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  function automatic int pick_gap(input bit on);
    int r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic pix_t pick_pixel(input pix_mode_t mode);
    case (mode)
      PIX_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      PIX_CLUSTER: return 8'($urandom_range(120, 123));
      PIX_SPECKLE: begin
        if ($urandom_range(0, 4) == 0) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return 8'd90;
      end
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_WIDTH_W-1:0] pick_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return CFG_WIDTH_W'($urandom_range(0, 2));
    if (r < 90) return CFG_WIDTH_W'($urandom_range(3, 12));
    return CFG_WIDTH_W'($urandom_range(13, 40));
  endfunction

  function automatic logic [CFG_HEIGHT_W-1:0] pick_height();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return CFG_HEIGHT_W'($urandom_range(0, 2));
    if (r < 85) return CFG_HEIGHT_W'($urandom_range(3, 9));
    if (r < 95) return CFG_HEIGHT_W'($urandom_range(10, 30));
    return CFG_HEIGHT_W'($urandom_range(4097, 8191));
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_IMAGE_WIDTH) begin
      img_w = data[CFG_WIDTH_W-1:0];
      sizes_written++;
    end else if (idx == REG_IMAGE_HEIGHT) begin
      img_h = data;
      sizes_written++;
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(input pix_t pix);
    int gap;
    gap = pick_gap(src_gaps_on);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    advance_window(pix);
    pixels_sent++;
  endtask

  task automatic send_pixels(input int unsigned n, input pix_mode_t mode);
    for (int unsigned i = 0; i < n; i++) send_pixel(pick_pixel(mode));
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every queued word, then for the pipeline to empty
  task automatic settle();
    int waited;
    waited = 0;
    while (medians_due.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_size();
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
    send_pixels(40, PIX_UNIFORM);
    settle();
    // shrink the frame part way along the first row
    write_reg(REG_IMAGE_WIDTH, 13'd5);
    write_reg(REG_IMAGE_HEIGHT, 13'd4);
    send_pixels(1 + 3 * 5, PIX_SPECKLE);
  endtask

  task automatic test_smallest_frame();
    pix_t frame_a [9];
    pix_t frame_b [9];
    frame_a = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
    frame_b = '{8'd200, 8'd13, 8'd77, 8'd5, 8'd128, 8'd255, 8'd64, 8'd1, 8'd99};
    settle();
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    write_reg(REG_IMAGE_HEIGHT, 13'd3);
    for (int i = 0; i < 9; i++) send_pixel(frame_a[i]);
    for (int i = 0; i < 9; i++) send_pixel(frame_b[i]);
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_small_sizes();
    int unsigned dw [5];
    int unsigned dh [5];
    dw = '{0, 2, 1, 2, 3};
    dh = '{3, 0, 2, 2, 2};
    settle();
    write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
    for (int k = 0; k < 5; k++) begin
      settle();
      write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(dw[k]));
      write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(dh[k]));
      send_pixels(2 * eff_width(CFG_WIDTH_W'(dw[k])) * eff_height(CFG_HEIGHT_W'(dh[k])),
                  PIX_UNIFORM);
    end
  endtask

  task automatic test_width_saturation();
    settle();
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
    write_reg(REG_IMAGE_HEIGHT, 13'd3);
    send_pixels(40, PIX_UNIFORM);
    settle();
    write_reg(REG_IMAGE_WIDTH, 13'd6);
    send_pixels(1 + 2 * 6, PIX_UNIFORM);
  endtask

  task automatic test_height_saturation();
    settle();
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
    send_pixels(3 * 6, PIX_UNIFORM);
    settle();
    write_reg(REG_IMAGE_HEIGHT, 13'd6);
    send_pixels(3, PIX_UNIFORM);
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  task automatic test_output_stall();
    settle();
    write_reg(REG_IMAGE_WIDTH, 13'd8);
    write_reg(REG_IMAGE_HEIGHT, 13'd6);
    src_gaps_on   = 1'b0;
    sink_hold_req = 1'b1;
    send_pixels(8 * 6, PIX_UNIFORM);
    src_gaps_on = 1'b1;
  endtask

  task automatic test_resize_in_frame();
    settle();
    write_reg(REG_IMAGE_WIDTH, 13'd10);
    write_reg(REG_IMAGE_HEIGHT, 13'd6);
    send_pixels(35, PIX_UNIFORM);
    settle();
    write_reg(REG_IMAGE_WIDTH, 13'd4);
    send_pixels(10, PIX_CLUSTER);
    settle();
    write_reg(REG_IMAGE_HEIGHT, 13'd3);
    if (width_fits(12'd10)) write_reg(REG_IMAGE_WIDTH, 13'd10);
    send_pixels(25, PIX_UNIFORM);
    settle();
    write_reg(REG_IMAGE_HEIGHT, 13'd9);
    send_pixels(40, PIX_EXTREME);
  endtask

  task automatic test_random_stream();
    int unsigned             px0;
    int unsigned             res0;
    int unsigned             rounds;
    bit                      do_w;
    bit                      do_h;
    bit                      at_start;
    logic [CFG_WIDTH_W-1:0]  w;
    logic [CFG_HEIGHT_W-1:0] h;
    px0    = pixels_sent;
    res0   = medians_predicted;
    rounds = 0;
    while ((pixels_sent - px0 < 110 || medians_predicted - res0 < 24) && rounds < 400) begin
      at_start = (col_pos == 0) && (row_pos == 0);
      w    = pick_width();
      h    = pick_height();
      do_w = (at_start || $urandom_range(0, 3) == 0) && (at_start || width_fits(w));
      do_h = $urandom_range(0, 2) == 0;
      if (do_w || do_h) settle();
      if (do_w) write_reg(REG_IMAGE_WIDTH, {1'($urandom_range(0, 1)), w});
      if (do_h) write_reg(REG_IMAGE_HEIGHT, h);
      src_gaps_on  = $urandom_range(0, 3) != 0;
      sink_gaps_on = $urandom_range(0, 3) != 0;
      send_pixels($urandom_range(1, 40), pix_mode_t'($urandom_range(0, 3)));
      rounds++;
    end
  endtask

  // output ready: random stalls, or one long hold on request
  initial begin : sink_ctrl
    int hold_cnt;
    out_tready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        out_tready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
        sink_hold_req = 1'b0;
      end else if (sink_gaps_on && $urandom_range(0, 99) < 30) begin
        out_tready <= 1'b0;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(8, 30)) @(posedge clk);
        else repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_out
    median_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (medians_due.size() == 0) begin
        report_mismatch("word with none due", out_tdata, 0);
      end else begin
        want = medians_due.pop_front();
        if (out_tdata[7:0] !== want.med)
          report_mismatch("median_value", out_tdata[7:0], want.med);
        if (out_tdata[18:8] !== want.col)
          report_mismatch("center_col", out_tdata[18:8], want.col);
        if (out_tdata[30:19] !== want.row)
          report_mismatch("center_row", out_tdata[30:19], want.row);
        if (out_tlast !== want.last)
          report_mismatch("frame_last", out_tlast, want.last);
        words_checked++;
      end
    end
  end

  initial begin : run_limit
    #(RUN_LIMIT);
    $display("Run limit reached with %0d words still due", medians_due.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin : main
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    reset_window_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_size();
    test_smallest_frame();
    test_small_sizes();
    test_width_saturation();
    test_height_saturation();
    test_output_stall();
    test_resize_in_frame();
    test_random_stream();

    settle();
    if (medians_due.size() != 0) report_mismatch("words never produced", 0, medians_due.size());
    $display("Sent %0d pixel words, checked %0d filtered words, %0d size writes",
             pixels_sent, words_checked, sizes_written);
    $display("Covered reset size, sizes below three, saturated width and height, resizing");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/mf3_pkg.sv
sv/mf3_line_store.sv
sv/mf3_raster.sv
sv/mf3_median9.sv
sv/median_filter_3x3.sv
verif/tb_median_filter_3x3.sv
